FILE: hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg - shared types and constants of the software timer table
// Slot entry layout, request and result codes, sequencer states.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

   localparam int REQ_W    = 2;
   localparam int HANDLE_W = 8;
   localparam int PER_W    = 8;
   localparam int KIND_W   = 2;
   localparam int CD_W     = 16;

   localparam logic signed [CD_W-1:0] CD_MIN = {1'b1, {(CD_W-1){1'b0}}};

   typedef enum logic [REQ_W-1:0] {
      REQ_START    = 2'd0,
      REQ_STOP     = 2'd1,
      REQ_TICK     = 2'd2,
      REQ_DISPATCH = 2'd3
   } req_code_type;

   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

   typedef struct packed {
      logic [HANDLE_W-1:0]     handle;
      logic [PER_W-1:0]        period;
      logic                    rep;
      logic signed [CD_W-1:0]  countdown;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

FILE: hdl/stt_if.sv
// ----------------------------------------------------------------------------
// stt_if - channel interfaces of the software timer table
// Request, response and control-register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface stt_req_if;
   import stt_pkg::*;
   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [HANDLE_W-1:0] timer_handle;
   logic [PER_W-1:0]    period;
   logic                periodic;
   modport source (output valid, req_type, timer_handle, period, periodic, input ready);
   modport sink   (input valid, req_type, timer_handle, period, periodic, output ready);
endinterface

interface stt_rsp_if;
   import stt_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic                ok;
   logic [HANDLE_W-1:0] fired_handle;
   logic                last;
   modport source (output valid, kind, ok, fired_handle, last, input ready);
   modport sink   (input valid, kind, ok, fired_handle, last, output ready);
endinterface

interface stt_csr_if;
   logic valid;
   logic ready;
   logic enabled;
   modport source (output valid, enabled, input ready);
   modport sink   (input valid, enabled, output ready);
endinterface

FILE: hdl/software_timer_table_top.sv
// ----------------------------------------------------------------------------
// software_timer_table_top - timer slot table with start/stop/tick/dispatch
// Slot contents live in one RAM; a sequencer sweeps it once per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  : one beat per request (start, stop, tick, dispatch).
//   rsp_if  : start, stop and tick return one acknowledge beat; dispatch
//             returns one fire beat per expired slot, then a summary beat.
//             The final beat of every request carries last = 1.
//   csr_if  : writes the enable bit; write it only while the block is idle.
// Timing:
//   Every request sweeps all NUM_SLOTS entries through the slot RAM, one
//   entry per cycle unless a due fire beat stalls the sweep, with the next
//   read overlapped: an accept step, the sweep, then a closing step. The
//   final beat is loaded in the closing step.
//   A new request is taken once the previous one has posted its final beat,
//   even if that beat still waits in the output register.
// Reset:
//   Clears the enable bit, every slot valid bit and the active count; the
//   RAM contents are not cleared and are read only behind a valid bit.
// Backpressure:
//   When the output register is full and a fire beat is due, the sweep holds
//   on its current slot until the receiver takes the pending beat.
// ----------------------------------------------------------------------------
module software_timer_table_top (
   input  logic  clock,
   input  logic  reset,
   stt_req_if.sink   req_if,
   stt_rsp_if.source rsp_if,
   stt_csr_if.sink   csr_if
);
   import stt_pkg::*;

   // control state
   state_type           state_ff, state_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [NUM_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [CNT_W-1:0]    active_count_ff, active_count_in;
   logic                enabled_ff;
   logic                hit_ff, hit_in;
   logic                free_found_ff, free_found_in;
   logic                all_exp_ff, all_exp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [SLOT_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [SLOT_W-1:0]   free_idx_ff, free_idx_in;
   logic [REQ_W-1:0]    op_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [PER_W-1:0]    period_ff;
   logic                periodic_ff;
   logic [KIND_W-1:0]   rsp_kind_ff;
   logic                rsp_ok_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic                rsp_last_ff;

   // datapath
   slot_entry_type      cur;
   slot_entry_type      wr_entry;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic                ram_wr_en, ram_rd_en;
   logic [SLOT_W-1:0]   ram_wr_addr, ram_rd_addr;

   logic                accept, out_free, last_idx;
   logic                cur_valid, cur_match, fire, tick_wr, advance;
   logic                start_ok, start_wr;
   logic                emit, emit_ok, emit_last;
   logic [KIND_W-1:0]   emit_kind;
   logic [HANDLE_W-1:0] emit_handle;
   logic signed [CD_W-1:0] reload_cd, start_cd;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign last_idx = (idx_ff == SLOT_W'(NUM_SLOTS - 1));

   assign cur       = slot_entry_type'(ram_rd_data);
   assign cur_valid = slot_valid_ff[idx_ff];
   assign cur_match = cur_valid && (cur.handle == handle_ff);
   assign fire      = (op_ff == REQ_DISPATCH) && cur_valid && (cur.countdown <= 0);
   assign tick_wr   = (op_ff == REQ_TICK) && cur_valid && (cur.countdown != CD_MIN);
   // stall only when a fire beat has nowhere to go
   assign advance   = !fire || out_free;

   assign reload_cd = cur.countdown + $signed({{(CD_W-PER_W){1'b0}}, cur.period});
   assign start_cd  = $signed({{(CD_W-PER_W){1'b0}}, period_ff});

   // start succeeds, when enabled with a nonzero period, on an existing handle or on a free slot
   assign start_ok = enabled_ff && (period_ff != '0) && (hit_ff || free_found_ff);
   assign start_wr = enabled_ff && (period_ff != '0) && !hit_ff && free_found_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (advance && last_idx) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      idx_in          = idx_ff;
      hit_in          = hit_ff;
      hit_idx_in      = hit_idx_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      all_exp_in      = all_exp_ff;
      slot_valid_in   = slot_valid_ff;
      active_count_in = active_count_ff;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = '0;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = idx_ff;
      wr_entry        = cur;
      emit            = 1'b0;
      emit_kind       = KIND_ACK;
      emit_ok         = 1'b0;
      emit_handle     = '0;
      emit_last       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // open the sweep at slot zero
               idx_in        = '0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               all_exp_in    = 1'b1;
               ram_rd_en     = 1'b1;
               ram_rd_addr   = '0;
            end
         end
         ST_SCAN: begin
            if (advance) begin
               if (cur_match && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = idx_ff;
               end
               if (!cur_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if ((op_ff == REQ_DISPATCH) && cur_valid && !fire) begin
                  all_exp_in = 1'b0;
               end
               if (tick_wr) begin
                  ram_wr_en          = 1'b1;
                  wr_entry.countdown = cur.countdown - 16'sd1;
               end
               if (fire) begin
                  emit        = 1'b1;
                  emit_kind   = KIND_FIRE;
                  emit_ok     = 1'b1;
                  emit_handle = cur.handle;
                  if (cur.rep) begin
                     ram_wr_en          = 1'b1;
                     wr_entry.countdown = reload_cd;
                  end else begin
                     slot_valid_in[idx_ff] = 1'b0;
                     active_count_in       = active_count_ff - CNT_W'(1);
                  end
               end
               if (!last_idx) begin
                  idx_in      = idx_ff + SLOT_W'(1);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_ff + SLOT_W'(1);
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               case (op_ff)
                  REQ_START: begin
                     emit_ok = start_ok;
                     if (start_wr) begin
                        ram_wr_en                  = 1'b1;
                        ram_wr_addr                = free_idx_ff;
                        wr_entry.handle            = handle_ff;
                        wr_entry.period            = period_ff;
                        wr_entry.rep               = periodic_ff;
                        wr_entry.countdown         = start_cd;
                        slot_valid_in[free_idx_ff] = 1'b1;
                        active_count_in            = active_count_ff + CNT_W'(1);
                     end
                  end
                  REQ_STOP: begin
                     emit_ok = hit_ff;
                     if (hit_ff) begin
                        slot_valid_in[hit_idx_ff] = 1'b0;
                        active_count_in           = active_count_ff - CNT_W'(1);
                     end
                  end
                  REQ_TICK: begin
                     emit_ok = 1'b1;
                  end
                  REQ_DISPATCH: begin
                     emit_kind = KIND_SUMMARY;
                     emit_ok   = all_exp_ff;
                  end
                  default: begin
                     emit_ok = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign ram_wr_data  = ram_wr_en ? wr_entry : cur;
   assign rsp_valid_in = emit ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   stt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         idx_ff          <= '0;
         slot_valid_ff   <= '0;
         active_count_ff <= '0;
         enabled_ff      <= 1'b0;
         hit_ff          <= 1'b0;
         free_found_ff   <= 1'b0;
         all_exp_ff      <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         idx_ff          <= idx_in;
         slot_valid_ff   <= slot_valid_in;
         active_count_ff <= active_count_in;
         hit_ff          <= hit_in;
         free_found_ff   <= free_found_in;
         all_exp_ff      <= all_exp_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            enabled_ff <= csr_if.enabled;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      if (accept) begin
         op_ff       <= req_if.req_type;
         handle_ff   <= req_if.timer_handle;
         period_ff   <= req_if.period;
         periodic_ff <= req_if.periodic;
      end
      if (emit) begin
         rsp_kind_ff   <= emit_kind;
         rsp_ok_ff     <= emit_ok;
         rsp_handle_ff <= emit_handle;
         rsp_last_ff   <= emit_last;
      end
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign csr_if.ready        = 1'b1;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.kind         = rsp_kind_ff;
   assign rsp_if.ok           = rsp_ok_ff;
   assign rsp_if.fired_handle = rsp_handle_ff;
   assign rsp_if.last         = rsp_last_ff;

   // the active count tracks the number of valid slots
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      active_count_ff == CNT_W'($countones(slot_valid_ff)))
      else $error("active count disagrees with slot valid bits");

   // an accepted request always starts a sweep
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN) && (idx_ff == '0))
      else $error("accepted request did not start a sweep");

   // a fire beat is never the final beat of a request
   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_FIRE)) |-> !rsp_last_ff)
      else $error("fire beat marked last");

   // while idle, only the final beat of the previous request can be pending
   a_idle_pending_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && rsp_valid_ff) |-> rsp_last_ff)
      else $error("non-final beat pending while idle");

   // the sweep index stays within the table
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= SLOT_W'(NUM_SLOTS - 1)))
      else $error("sweep index out of range");

endmodule

FILE: hdl/stt_ram.sv
// ----------------------------------------------------------------------------
// stt_ram - generic single-clock RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module stt_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
